>>> sv/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared definitions for the WebSocket frame deframer
// Length width, queue sizing, configuration address map and the command
// that the header parser hands to the output stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Width of the accepted payload length; longer frames are rejected.
    localparam int LEN_WIDTH = 24;

    // Command queue between the parser and the output stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_DELIVER_ENABLE = 1'b0;

    // Header field codes.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'h7e;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'h7f;

    typedef enum logic [1:0] {
        K_DATA,
        K_EMPTY,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       last;
    } t_cmd;

endpackage

>>> sv/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket frame parser
// Parses a received byte stream into unmasked payload beats, empty-frame
// markers and error reports.
// ----------------------------------------------------------------------------
// The block takes one stream byte per beat and, unless stalled, accepts a
// byte in each cycle. A header parser decodes the FIN bit, opcode, mask bit,
// the 7-bit, 16-bit or 64-bit length and the optional 4-byte masking key,
// then passes one command per payload byte, empty frame or rejected frame
// into a four-entry command queue. An output stage drains that queue, XORs
// each payload byte with the rotating key byte and holds the result in an
// output register. Results reach it through the parser register and a
// queue entry. Input stall is raised while the command queue is full, or
// while it holds three commands and a fourth is on its way from the parser,
// so a stalled output costs nothing until five results are waiting in the
// block. A frame without FIN, or a 64-bit length that does not fit in 24
// bits, produces one error beat, after which all bytes are taken and dropped
// until reset. The deliver_enable register (byte address 0, bit 0, reset 1)
// suppresses payload and empty-frame beats when cleared; error beats are
// always reported. Write it only while the block is idle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input byte channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_in_byte,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_data_byte,
    output logic [3:0]                  o_frame_opcode,
    output logic                        o_last_in_frame,
    output logic                        o_empty_frame,
    output logic                        o_error,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wsd_pkg::PADDR_W-1:0] paddr,
    input  logic [wsd_pkg::PDATA_W-1:0] pwdata,
    output logic [wsd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic          r_deliver;
    logic          w_accept;
    logic          w_push;
    wsd_pkg::t_cmd w_push_cmd;
    wsd_pkg::t_cmd w_head_cmd;
    logic          w_avail;
    logic          w_full;
    logic          w_full_q;
    logic          w_almost;
    logic          w_pop;
    logic          w_sel_deliver;

    // The register decode ignores the byte offset within the word.
    assign w_sel_deliver = (paddr[wsd_pkg::PADDR_W-1:2] == wsd_pkg::REG_DELIVER_ENABLE);
    assign pready        = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deliver <= 1'b1;
        end else if (psel && penable && pwrite && w_sel_deliver) begin
            r_deliver <= pwdata[0];
        end
    end

    assign prdata = w_sel_deliver ? wsd_pkg::PDATA_W'(r_deliver) : '0;

    // A byte is taken whenever the queue has room for the command it may yield.
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    wsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_byte    (i_in_byte),
        .i_deliver (r_deliver),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // The parser pushes in the cycle after acceptance, so the full flag must
    // leave room for that in-flight command: it counts against the queue
    // through the registered push.
    wsd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_avail  (w_avail),
        .o_full   (w_full_q),
        .o_almost (w_almost)
    );

    // Reserve one slot for a command still held in the parser's output
    // register, so that a push never meets a full queue.
    assign w_full = w_full_q || (w_push && w_almost);

    wsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_head_cmd),
        .i_avail         (w_avail),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_data_byte     (o_data_byte),
        .o_frame_opcode  (o_frame_opcode),
        .o_last_in_frame (o_last_in_frame),
        .o_empty_frame   (o_empty_frame),
        .o_error         (o_error)
    );

endmodule

>>> sv/wsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front: frame header parser
// Walks the frame header one byte per beat, tracks the payload length and
// the masking key, and issues one command per byte that yields a result.
// ----------------------------------------------------------------------------
module wsd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_deliver,
    output logic                  o_push,
    output wsd_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_HDR0,
        S_HDR1,
        S_EXT16,
        S_EXT64,
        S_MASK,
        S_PAY
    } t_phase;

    localparam int LW = wsd_pkg::LEN_WIDTH;

    t_phase        r_phase, n_phase;
    logic [3:0]    r_opcode, n_opcode;
    logic          r_mask, n_mask;
    logic [31:0]   r_key, n_key;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_rem, n_rem;
    logic [2:0]    r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_halt, n_halt;
    logic          r_push, n_push;
    wsd_pkg::t_cmd r_cmd, n_cmd;

    always_comb begin
        logic          v_done;
        logic          v_start;
        logic [LW-1:0] v_len;

        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_key    = r_key;
        n_len    = r_len;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_halt   = r_halt;
        n_push   = 1'b0;
        n_cmd    = '0;
        v_done   = 1'b0;
        v_start  = 1'b0;
        v_len    = r_len;

        if (i_accept && !r_halt) begin
            unique case (r_phase)
                S_HDR1: begin
                    n_mask = i_byte[7];
                    n_cnt  = '0;
                    n_ovf  = 1'b0;
                    n_len  = '0;
                    if (i_byte[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
                        n_phase = S_EXT16;
                    end else if (i_byte[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
                        n_phase = S_EXT64;
                    end else begin
                        v_len  = LW'(i_byte[6:0]);
                        n_len  = v_len;
                        v_done = 1'b1;
                    end
                end
                S_EXT16: begin
                    v_len = LW'({r_len[7:0], i_byte});
                    n_len = v_len;
                    n_cnt = r_cnt + 3'd1;
                    v_done = (r_cnt == 3'd1);
                end
                S_EXT64: begin
                    // Any bit shifted out of the length register is above the limit.
                    n_ovf = r_ovf | (r_len[LW-1 -: 8] != 8'd0);
                    v_len = {r_len[LW-9:0], i_byte};
                    n_len = v_len;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        if (n_ovf) begin
                            n_halt     = 1'b1;
                            n_phase    = S_HDR0;
                            n_push     = 1'b1;
                            n_cmd.kind = wsd_pkg::K_ERROR;
                        end else begin
                            v_done = 1'b1;
                        end
                    end
                end
                S_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = r_cnt + 3'd1;
                    v_start = (r_cnt == 3'd3);
                end
                S_PAY: begin
                    n_push       = i_deliver;
                    n_cmd.kind   = wsd_pkg::K_DATA;
                    n_cmd.data   = i_byte;
                    n_cmd.key    = r_mask ? r_key[31:24] : 8'd0;
                    n_cmd.opcode = r_opcode;
                    n_cmd.last   = (r_rem == LW'(1));
                    n_key        = {r_key[23:0], r_key[31:24]};
                    n_rem        = r_rem - LW'(1);
                    if (r_rem == LW'(1)) begin
                        n_phase = S_HDR0;
                    end
                end
                default: begin
                    n_opcode = i_byte[3:0];
                    if (!i_byte[7]) begin
                        n_halt     = 1'b1;
                        n_phase    = S_HDR0;
                        n_push     = 1'b1;
                        n_cmd.kind = wsd_pkg::K_ERROR;
                    end else begin
                        n_phase = S_HDR1;
                    end
                end
            endcase

            if (v_done) begin
                if (n_mask) begin
                    n_phase = S_MASK;
                    n_cnt   = '0;
                    n_key   = '0;
                end else begin
                    v_start = 1'b1;
                end
            end

            if (v_start) begin
                n_rem = v_len;
                if (v_len == '0) begin
                    n_phase      = S_HDR0;
                    n_push       = i_deliver;
                    n_cmd.kind   = wsd_pkg::K_EMPTY;
                    n_cmd.opcode = n_opcode;
                    n_cmd.last   = 1'b1;
                end else begin
                    n_phase = S_PAY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= S_HDR0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_key    <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_halt   <= 1'b0;
            r_push   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_key    <= n_key;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_halt   <= n_halt;
            r_push   <= n_push;
        end
        r_cmd <= n_cmd;
    end

    assign o_push = r_push;
    assign o_cmd  = r_cmd;

endmodule

>>> sv/wsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_queue: command queue
// A small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wsd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output wsd_pkg::t_cmd o_cmd,
    output logic          o_avail,
    output logic          o_full,
    output logic          o_almost
);

    wsd_pkg::t_cmd                     r_mem [wsd_pkg::QDEPTH];
    logic [wsd_pkg::QPTR_W-1:0]        r_wptr, r_rptr;
    logic [wsd_pkg::QCNT_W-1:0]        r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd    = r_mem[r_rptr];
    assign o_avail  = (r_count != '0);
    assign o_full   = (r_count == wsd_pkg::QCNT_W'(wsd_pkg::QDEPTH));
    // One entry left: a command already on its way takes it.
    assign o_almost = (r_count == wsd_pkg::QCNT_W'(wsd_pkg::QDEPTH - 1));

endmodule

>>> sv/wsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back: result stage
// Takes commands from the queue, unmasks payload bytes and holds each result
// in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wsd_pkg::t_cmd i_cmd,
    input  logic          i_avail,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [7:0]    o_data_byte,
    output logic [3:0]    o_frame_opcode,
    output logic          o_last_in_frame,
    output logic          o_empty_frame,
    output logic          o_error
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [3:0] r_opcode;
    logic       r_last;
    logic       r_empty;
    logic       r_error;

    assign o_pop = i_avail && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_avail;
        end
        if (o_pop) begin
            r_data   <= (i_cmd.kind == wsd_pkg::K_DATA) ? (i_cmd.data ^ i_cmd.key) : 8'd0;
            r_opcode <= i_cmd.opcode;
            r_last   <= i_cmd.last;
            r_empty  <= (i_cmd.kind == wsd_pkg::K_EMPTY);
            r_error  <= (i_cmd.kind == wsd_pkg::K_ERROR);
        end
    end

    assign o_out_valid     = r_valid;
    assign o_data_byte     = r_data;
    assign o_frame_opcode  = r_opcode;
    assign o_last_in_frame = r_last;
    assign o_empty_frame   = r_empty;
    assign o_error         = r_error;

endmodule

>>> test/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb: self-checking bench for the frame deframer
// Feeds the deframer whole WebSocket frames one byte per beat. Frames use
// every header length form, with and without a masking key, random opcodes
// and random RSV bits. A byte-level parser in the bench predicts every
// result beat, and each beat leaving the block is compared with the oldest
// prediction. Delivery is switched off and on between phases. The run ends
// with one rejected frame, followed by bytes that the block has to drop.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int LW = wsd_pkg::LEN_WIDTH;

    // Length encodings that a header can use.
    localparam int FORM7 = 0;
    localparam int FORM16 = 1;
    localparam int FORM64 = 2;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] opcode;
        logic       is_last;
        logic       is_empty;
        logic       is_err;
    } t_ws_beat;

    // Where the parser stands within the current frame.
    typedef enum logic [2:0] {
        P_HDR0,
        P_HDR1,
        P_EXT16,
        P_EXT64,
        P_MASK,
        P_PAYLOAD
    } t_parse_phase;

    // ------------------------------------------------------------------------
    // Frame parser and result store. parse_byte() follows every accepted byte
    // and queues the beat that it should cause; check_beat() pops the oldest
    // queued beat and compares it with what the block delivered.
    // ------------------------------------------------------------------------
    class ws_frame_scoreboard;
        bit                   deliver;
        t_parse_phase         phase;
        logic [3:0]           opcode_held;
        logic                 masked;
        logic [31:0]          key;
        logic [63:0]          frame_len;
        logic [LW-1:0]        pay_idx;
        logic [3:0]           hdr_cnt;
        bit                   halted;
        t_ws_beat             expected_beats[$];
        int                   mismatches;

        function new();
            deliver = 1'b1;
            phase = P_HDR0;
            opcode_held = '0;
            masked = 1'b0;
            key = '0;
            frame_len = '0;
            pay_idx = '0;
            hdr_cnt = '0;
            halted = 1'b0;
            mismatches = 0;
        endfunction

        function void set_deliver(bit v);
            deliver = v;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // A rejected frame reports once and freezes the parser until reset.
        function void flag_error();
            t_ws_beat b;
            halted = 1'b1;
            phase = P_HDR0;
            b = '{data: 8'h00, opcode: 4'h0, is_last: 1'b0, is_empty: 1'b0, is_err: 1'b1};
            expected_beats.push_back(b);
        endfunction

        function void open_payload();
            t_ws_beat b;
            pay_idx = '0;
            if (frame_len == 0) begin
                phase = P_HDR0;
                if (deliver) begin
                    b = '{data: 8'h00, opcode: opcode_held, is_last: 1'b1,
                          is_empty: 1'b1, is_err: 1'b0};
                    expected_beats.push_back(b);
                end
            end else begin
                phase = P_PAYLOAD;
            end
        endfunction

        function void finish_length();
            if (masked) begin
                phase = P_MASK;
                hdr_cnt = '0;
                key = '0;
            end else begin
                open_payload();
            end
        endfunction

        function void parse_byte(logic [7:0] b);
            logic [7:0] d;
            logic       fin_byte;
            t_ws_beat   r;
            if (halted) return;
            case (phase)
                P_HDR1: begin
                    masked = b[7];
                    frame_len = '0;
                    hdr_cnt = '0;
                    if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
                        phase = P_EXT16;
                    end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
                        phase = P_EXT64;
                    end else begin
                        frame_len = {57'd0, b[6:0]};
                        finish_length();
                    end
                end
                P_EXT16: begin
                    frame_len = {48'd0, frame_len[7:0], b};
                    hdr_cnt++;
                    if (hdr_cnt >= 2) finish_length();
                end
                P_EXT64: begin
                    frame_len = {frame_len[55:0], b};
                    hdr_cnt++;
                    if (hdr_cnt >= 8) begin
                        if ((frame_len >> LW) != 0) flag_error();
                        else finish_length();
                    end
                end
                P_MASK: begin
                    key = {key[23:0], b};
                    hdr_cnt++;
                    if (hdr_cnt >= 4) open_payload();
                end
                P_PAYLOAD: begin
                    // Key byte 0 is the first key byte on the wire, so it
                    // sits in the top byte of the shifted-in key.
                    d = masked ? (b ^ key[8 * (3 - pay_idx[1:0]) +: 8]) : b;
                    fin_byte = (64'(pay_idx) + 64'd1 >= frame_len);
                    pay_idx = pay_idx + 1'b1;
                    if (fin_byte) phase = P_HDR0;
                    if (deliver) begin
                        r = '{data: d, opcode: opcode_held, is_last: fin_byte,
                              is_empty: 1'b0, is_err: 1'b0};
                        expected_beats.push_back(r);
                    end
                end
                default: begin
                    opcode_held = b[3:0];
                    if (!b[7]) flag_error();
                    else phase = P_HDR1;
                end
            endcase
        endfunction

        task check_beat(t_ws_beat got);
            t_ws_beat want;
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected beat data=%h op=%h last=%b empty=%b err=%b",
                                 got.data, got.opcode, got.is_last, got.is_empty,
                                 got.is_err));
            end else begin
                want = expected_beats.pop_front();
                if (got !== want)
                    report($sformatf({"beat data=%h op=%h last=%b empty=%b err=%b, ",
                                      "wanted data=%h op=%h last=%b empty=%b err=%b"},
                                     got.data, got.opcode, got.is_last, got.is_empty,
                                     got.is_err, want.data, want.opcode, want.is_last,
                                     want.is_empty, want.is_err));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [7:0]                   i_in_byte = 8'h00;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [7:0]                   o_data_byte;
    logic [3:0]                   o_frame_opcode;
    logic                         o_last_in_frame;
    logic                         o_empty_frame;
    logic                         o_error;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [wsd_pkg::PADDR_W-1:0]  paddr = '0;
    logic [wsd_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [wsd_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    ws_frame_scoreboard sb;

    // Idle rates in percent for the byte sender and the result receiver.
    int in_idle_pct = 16;
    int out_idle_pct = 16;
    int bytes_sent = 0;

    // The main sequence raises hold_trigger once; the receiver process then
    // keeps its stall high until its own count reaches HOLD_CYCLES.
    bit hold_trigger = 1'b0;
    int hold_cnt = 0;

    websocket_frame_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_byte     (o_data_byte),
        .o_frame_opcode  (o_frame_opcode),
        .o_last_in_frame (o_last_in_frame),
        .o_empty_frame   (o_empty_frame),
        .o_error         (o_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Result receiver. Stall changes only on the falling edge, so the value
    // seen at the rising edge is the one the block saw as well.
    always @(negedge i_clk) begin
        if (hold_trigger && hold_cnt < HOLD_CYCLES) begin
            i_out_stall = 1'b1;
            hold_cnt++;
        end else begin
            i_out_stall = ($urandom_range(99) < out_idle_pct);
        end
    end

    // Every beat that leaves the block goes straight to the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat('{data: o_data_byte, opcode: o_frame_opcode,
                            is_last: o_last_in_frame, is_empty: o_empty_frame,
                            is_err: o_error});
    end

    // Offers one byte, with a random gap in front of it now and then, and
    // returns on the rising edge at which the block takes it. Valid is left
    // high; the next call or drain_block decides what it does next.
    task automatic send_byte(logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(99) < in_idle_pct) begin
            gap = $urandom_range(3, 1);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.parse_byte(b);
        bytes_sent++;
    endtask

    // Sends one frame. With extremes set, the payload alternates between all
    // zeros and all ones; otherwise it is random. An oversized length sends
    // no payload, since the block drops everything after it anyway.
    task automatic send_frame(logic [3:0] op, logic [2:0] rsv, bit masked, int form,
                              logic [63:0] length, bit fin = 1'b1, bit extremes = 1'b0);
        logic [31:0] key;
        key = $urandom;
        send_byte({fin, rsv, op});
        case (form)
            FORM16: begin
                send_byte({masked, wsd_pkg::LEN_CODE_EXT16});
                send_byte(length[15:8]);
                send_byte(length[7:0]);
            end
            FORM64: begin
                send_byte({masked, wsd_pkg::LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(length[8 * i +: 8]);
            end
            default: send_byte({masked, length[6:0]});
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        if ((length >> LW) == 0)
            for (longint n = 0; n < length; n++)
                send_byte(extremes ? (n[0] ? 8'hff : 8'h00) : 8'($urandom_range(255)));
    endtask

    // Mostly short frames, some empty ones, a few that need an extension.
    // Short lengths are sometimes sent in the longer forms, which is legal.
    task automatic random_frame();
        int          pick;
        int          form;
        logic [63:0] length;
        pick = $urandom_range(99);
        if (pick < 10) length = 0;
        else if (pick < 75) length = $urandom_range(12, 1);
        else if (pick < 95) length = $urandom_range(125, 13);
        else length = $urandom_range(200, 126);
        pick = $urandom_range(99);
        if (length > 125) form = (pick < 50) ? FORM16 : FORM64;
        else form = (pick < 60) ? FORM7 : ((pick < 85) ? FORM16 : FORM64);
        send_frame(4'($urandom_range(15)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                   form, length);
    endtask

    // Drops valid, waits for every predicted beat, then lets the block
    // settle so that frames with no result are done as well.
    task automatic drain_block(int settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes deliver_enable through a setup and an access cycle, then reads
    // it back. Only called while the block is idle.
    task automatic write_deliver(bit v);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {wsd_pkg::REG_DELIVER_ENABLE, 2'b00};
        pwdata = {{(wsd_pkg::PDATA_W - 1){1'b0}}, v};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_deliver(v);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[0] !== v)
            sb.report($sformatf("deliver_enable reads %b after writing %b", prdata[0], v));
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        logic [63:0] big_len;
        bit          keep_deliver;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames: an empty frame, a masked frame whose payload
        // swings between all zeros and all ones, a frame with every bit of the first
        // header byte set using the 16-bit length, and a 64-bit length form.
        send_frame(4'h1, 3'b000, 1'b0, FORM7, 64'd0);
        send_frame(4'h2, 3'b000, 1'b1, FORM7, 64'd2, 1'b1, 1'b1);
        send_frame(4'hf, 3'b111, 1'b0, FORM16, 64'd1, 1'b1, 1'b1);
        send_frame(4'h0, 3'b000, 1'b0, FORM64, 64'd1, 1'b1, 1'b1);

        // Delivery on. After the first frame the receiver holds off for a
        // long stretch while frames keep coming, so the block backs up.
        bytes_sent = 0;
        random_frame();
        hold_trigger = 1'b1;
        while (bytes_sent < 300) random_frame();
        drain_block(SETTLE_CYCLES);

        // Delivery off: payload and empty frames vanish without a trace.
        write_deliver(1'b0);
        while (bytes_sent < 450) random_frame();
        drain_block(SETTLE_CYCLES);

        // Delivery on again, with a stretch in which neither side idles
        // and one long frame that needs the 16-bit length.
        write_deliver(1'b1);
        in_idle_pct = 0;
        out_idle_pct = 0;
        while (bytes_sent < 600) random_frame();
        in_idle_pct = 16;
        out_idle_pct = 16;
        send_frame(4'($urandom_range(15)), 3'b000, 1'b1, FORM16, 64'd300);
        while (bytes_sent < 850) random_frame();
        drain_block(SETTLE_CYCLES);

        // One rejected frame ends the parse for good: either FIN is missing
        // or the 64-bit length does not fit. The error beat comes out even
        // with delivery off, and the bytes after it must all be dropped.
        keep_deliver = $urandom_range(1);
        if (!keep_deliver) write_deliver(1'b0);
        if ($urandom_range(1)) begin
            send_frame(4'($urandom_range(15)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                       FORM7, 64'($urandom_range(8)), 1'b0);
        end else begin
            big_len = {$urandom, $urandom};
            big_len[LW + $urandom_range(63 - LW)] = 1'b1;
            if ($urandom_range(1)) big_len = 64'd1 << LW;
            send_frame(4'($urandom_range(15)), 3'b000, 1'($urandom_range(1)), FORM64, big_len);
        end
        repeat (12) send_byte(8'($urandom_range(255)));
        drain_block(10);

        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Far beyond the slowest correct run of roughly a thousand bytes.
    initial begin
        #5ms;
        $display("[%0t] timeout, %0d beats still expected", $realtime, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
